// ===== hw/rtl/slfc_pkg.sv =====
// Shared types, constants and lookup functions for the sensor link frame codec.
// Depends on nothing; every other file of the codec depends on it.
package slfc_pkg;

  localparam int unsigned TYPE_W = 5;

  localparam logic [7:0] FRAME_HEADER   = 8'h2A;
  localparam logic [7:0] CRC_POLY       = 8'h31;
  localparam logic [7:0] CRC_INIT       = 8'hFF;
  localparam logic [7:0] FLAG_SYS_ERR   = 8'h31;
  localparam logic [7:0] FLAG_FRAME_ERR = 8'h32;
  localparam logic [7:0] FILLER_BYTE    = 8'h55;
  localparam logic [TYPE_W-1:0] TYPE_COUNT = 5'd20;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADTYPE = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;

  // Operation codes
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Packing rules for building a frame
  localparam logic [1:0] PK_PARAM_FILL = 2'd0;  // param low byte, filler
  localparam logic [1:0] PK_ZERO_FILL  = 2'd1;  // zero, filler
  localparam logic [1:0] PK_ZERO_PARAM = 2'd2;  // zero, param low byte
  localparam logic [1:0] PK_FULL       = 2'd3;  // whole 16-bit parameter

  // Parsing rules for a received frame
  localparam logic [2:0] PR_FFZ_LOW  = 3'd0;  // reject FF/00, low byte
  localparam logic [2:0] PR_FF_LOW   = 3'd1;  // reject high FF, low byte
  localparam logic [2:0] PR_FF_FULL  = 3'd2;  // reject high FF, 16-bit value
  localparam logic [2:0] PR_CALIB    = 3'd3;  // calibration acknowledge
  localparam logic [2:0] PR_FFZ_FULL = 3'd4;  // reject FF/00, 16-bit value

  typedef struct packed {
    logic              operation;
    logic [TYPE_W-1:0] control_type;
    logic [15:0]       parameter_req;
    logic [7:0]        rx_header;
    logic [7:0]        rx_flag;
    logic [7:0]        rx_data_high;
    logic [7:0]        rx_data_low;
    logic [7:0]        rx_check;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  tx_header;
    logic [7:0]  tx_flag;
    logic [7:0]  tx_data_high;
    logic [7:0]  tx_data_low;
    logic [7:0]  tx_check;
    logic [15:0] value;
    logic [1:0]  status;
  } out_word_t;

  function automatic logic [7:0] flag_of(input logic [TYPE_W-1:0] ty);
    logic [7:0] f;
    case (ty)
      5'd0:    f = 8'h2F;
      5'd1:    f = 8'h2E;
      5'd2:    f = 8'h22;
      5'd3:    f = 8'h23;
      5'd4:    f = 8'h24;
      5'd5:    f = 8'h25;
      5'd6:    f = 8'h26;
      5'd7:    f = 8'h91;
      5'd8:    f = 8'h92;
      5'd9:    f = 8'h93;
      5'd10:   f = 8'h94;
      5'd11:   f = 8'h97;
      5'd12:   f = 8'h95;
      5'd13:   f = 8'h96;
      5'd14:   f = 8'hC1;
      5'd15:   f = 8'hC2;
      5'd16:   f = 8'hC3;
      5'd17:   f = 8'hC4;
      5'd18:   f = 8'hC6;
      5'd19:   f = 8'hC7;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

  function automatic logic [1:0] pack_rule_of(input logic [TYPE_W-1:0] ty);
    logic [1:0] r;
    case (ty)
      5'd0, 5'd5:                           r = PK_PARAM_FILL;
      5'd1, 5'd2, 5'd3, 5'd4, 5'd6, 5'd11:  r = PK_ZERO_FILL;
      5'd7, 5'd12, 5'd13, 5'd16:            r = PK_FULL;
      default:                              r = PK_ZERO_PARAM;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] parse_rule_of(input logic [TYPE_W-1:0] ty);
    logic [2:0] r;
    case (ty)
      5'd1, 5'd3, 5'd8, 5'd9, 5'd10:  r = PR_FF_LOW;
      5'd2, 5'd4, 5'd5, 5'd6, 5'd7:   r = PR_FF_FULL;
      5'd11:                          r = PR_CALIB;
      5'd12, 5'd13, 5'd16:            r = PR_FFZ_FULL;
      default:                        r = PR_FFZ_LOW;
    endcase
    return r;
  endfunction

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // CRC over flag and both data bytes; a fixed XOR network.
  function automatic logic [7:0] crc3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    return crc_byte(crc_byte(crc_byte(CRC_INIT, a), b), c);
  endfunction

endpackage

// ===== hw/rtl/slfc_in_if.sv =====
// Input channel of the frame codec: valid/ready handshake with one request word.
// Depends on slfc_pkg for the word type.
interface slfc_in_if;
  logic                valid;
  logic                ready;
  slfc_pkg::in_word_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/slfc_out_if.sv =====
// Result channel of the frame codec: valid/ready handshake with one result word.
// Depends on slfc_pkg for the word type.
interface slfc_out_if;
  logic                valid;
  logic                ready;
  slfc_pkg::out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/slfc_build.sv =====
// Command frame builder: flag lookup, data byte packing and CRC.
// Depends on slfc_pkg.
module slfc_build (
  input  slfc_pkg::in_word_t  req,
  output slfc_pkg::out_word_t res
);
  import slfc_pkg::*;

  logic [7:0] flag;
  logic [7:0] dh;
  logic [7:0] dl;

  always_comb begin
    flag = flag_of(req.control_type);
    case (pack_rule_of(req.control_type))
      PK_PARAM_FILL: begin
        dh = req.parameter_req[7:0];
        dl = FILLER_BYTE;
      end
      PK_ZERO_FILL: begin
        dh = 8'h00;
        dl = FILLER_BYTE;
      end
      PK_ZERO_PARAM: begin
        dh = 8'h00;
        dl = req.parameter_req[7:0];
      end
      default: begin
        dh = req.parameter_req[15:8];
        dl = req.parameter_req[7:0];
      end
    endcase
  end

  always_comb begin
    res = '0;
    if (req.control_type >= TYPE_COUNT) begin
      res.status = ST_BADTYPE;
    end else begin
      res.tx_header    = FRAME_HEADER;
      res.tx_flag      = flag;
      res.tx_data_high = dh;
      res.tx_data_low  = dl;
      res.tx_check     = crc3(flag, dh, dl);
      res.status       = ST_OK;
    end
  end

endmodule

// ===== hw/rtl/slfc_check.sv =====
// Received frame checker: header, flag and CRC tests, then per-type parsing.
// Depends on slfc_pkg.
module slfc_check (
  input  slfc_pkg::in_word_t  req,
  output slfc_pkg::out_word_t res
);
  import slfc_pkg::*;

  logic        frame_bad;
  logic        parse_bad;
  logic        ffzero;
  logic [15:0] parsed;

  assign frame_bad = (req.rx_header != FRAME_HEADER) ||
                     (req.rx_flag == FLAG_SYS_ERR) || (req.rx_flag == FLAG_FRAME_ERR) ||
                     (req.rx_flag != flag_of(req.control_type)) ||
                     (req.rx_check != crc3(req.rx_flag, req.rx_data_high, req.rx_data_low));

  assign ffzero = (req.rx_data_high == 8'hFF) && (req.rx_data_low == 8'h00);

  always_comb begin
    case (parse_rule_of(req.control_type))
      PR_FFZ_LOW: begin
        parse_bad = ffzero;
        parsed    = {8'h00, req.rx_data_low};
      end
      PR_FF_LOW: begin
        parse_bad = (req.rx_data_high == 8'hFF);
        parsed    = {8'h00, req.rx_data_low};
      end
      PR_FF_FULL: begin
        parse_bad = (req.rx_data_high == 8'hFF);
        parsed    = {req.rx_data_high, req.rx_data_low};
      end
      PR_CALIB: begin
        // Calibration only acknowledges the fixed pattern 00/55.
        parse_bad = !((req.rx_data_high == 8'h00) && (req.rx_data_low == FILLER_BYTE));
        parsed    = 16'h0000;
      end
      default: begin
        parse_bad = ffzero;
        parsed    = {req.rx_data_high, req.rx_data_low};
      end
    endcase
  end

  always_comb begin
    res = '0;
    if (req.control_type >= TYPE_COUNT) begin
      res.status = ST_BADTYPE;
    end else if (frame_bad || parse_bad) begin
      res.status = ST_REJECT;
    end else begin
      res.value  = parsed;
      res.status = ST_OK;
    end
  end

endmodule

// ===== hw/rtl/sensor_link_frame_codec_unit.sv =====
// Top level of the sensor link frame codec: input register, builder and
// checker, result register. Depends on slfc_pkg, slfc_in_if, slfc_out_if,
// slfc_build and slfc_check.
//
//   channel   direction  handshake        word
//   in_if     sink       valid / ready    slfc_pkg::in_word_t (request)
//   out_if    source     valid / ready    slfc_pkg::out_word_t (result)
//
// A word's result is offered from the result register: the word first sits in
// the input register, then moves on to the result register once that is free.
// One word is taken every cycle while the result side keeps accepting; flag
// lookup, CRC and compares sit between the two registers.
// Reset (rst_n low at a clock edge) empties both stages. A stall at out_if
// holds the result register and the input register fills behind it; in_if
// then drops ready until the result is taken.
module sensor_link_frame_codec_unit (
  input logic              clk,
  input logic              rst_n,
  slfc_in_if.sink          in_if,
  slfc_out_if.source       out_if
);
  import slfc_pkg::*;

  // Input register stage
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  in_word_t  s1_word_r;

  // Result register stage
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_word_t out_word_r;

  out_word_t build_res;
  out_word_t check_res;
  out_word_t result;

  logic      out_free;   // result register can take a new word this cycle
  logic      s1_adv;     // input stage hands its word on
  logic      in_take;

  // The result register frees up when empty or when its word is being taken;
  // the input stage may then advance, and so may take a new word.
  assign out_free = !out_valid_r || out_if.ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || out_free;
  assign in_take  = in_if.valid && in_if.ready;

  slfc_build u_build (
    .req (s1_word_r),
    .res (build_res)
  );

  slfc_check u_check (
    .req (s1_word_r),
    .res (check_res)
  );

  assign result = (s1_word_r.operation == OP_CHECK) ? check_res : build_res;

  always_comb begin
    s1_valid_nxt = in_take || (s1_valid_r && !out_free);
    out_valid_nxt = s1_adv || (out_valid_r && !out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; the valid flags qualify them.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_if.payload;
    end
    if (s1_adv) begin
      out_word_r <= result;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_word_r;

`ifndef NO_ASSERTIONS
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("word from input stage did not reach result register");

  a_bad_type_status: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_word_r.control_type >= TYPE_COUNT)) |=>
      (out_word_r.status == ST_BADTYPE))
    else $error("invalid control type not flagged");

  a_value_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.status != ST_OK)) |-> (out_word_r.value == 16'h0000))
    else $error("value not zero on failed result");

  a_reject_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.status == ST_REJECT)) |-> (out_word_r.tx_header == 8'h00))
    else $error("rejected frame carries built bytes");
`endif

endmodule
